// ===== hw/rtl/qpht_pkg.sv =====
// Shared constants, codes and control types of the quadratic-probe hash table.
// No dependencies; every other file of the block imports this package.
package qpht_pkg;

  localparam int SLOT_CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF      = 31;

  localparam int SIZE_W     = 11;     // table size register width
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SIZE_RESET = 1021;
  localparam int SIZE_MIN   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_LIMIT     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_MISSING   = 3'd4,
    ST_REMOVED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    div_step;
    logic    probe_adv;
    logic    wr_insert;
    logic    wr_remove;
    logic    set_status;
    status_t status;
    logic    out_load;
  } qpht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              clr_last;
    logic              div_last;
    logic              mark_empty;
    logic              mark_used;
    logic              key_match;
    logic              probe_last;
    logic              out_free;
    logic [KIND_W-1:0] kind;
  } qpht_sts_t;

endpackage

// ===== hw/rtl/qpht_if.sv =====
// Request and response channel interfaces of the hash table (valid/ready).
// Depends on qpht_pkg for field widths and parameter defaults.
interface qpht_req_if #(
  parameter int KEY_BITS = qpht_pkg::KEY_BITS_DEF
) ();
  import qpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

interface qpht_rsp_if #(
  parameter int SLOT_W = $clog2(qpht_pkg::SLOT_CAPACITY_DEF),
  parameter int CNT_W  = $clog2(qpht_pkg::SLOT_CAPACITY_DEF + 1)
) ();
  import qpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    occupancy;

  modport source (output valid, status, slot, occupancy, input ready);
  modport sink   (input valid, status, slot, occupancy, output ready);
endinterface

// ===== hw/rtl/qpht_ctrl.sv =====
// Request sequencer: clear pass, key hashing, probe loop and result hand-off.
// Depends on qpht_pkg; drives the datapath through qpht_cmd_t only.
module qpht_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [qpht_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  input  qpht_pkg::qpht_sts_t        sts,
  output qpht_pkg::qpht_cmd_t        cmd
);
  import qpht_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_INSERT || in_kind == KIND_SEARCH || in_kind == KIND_REMOVE)
            state_nxt = S_DIV;
          else
            state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.kind == KIND_INSERT) begin
          if (!sts.mark_used || sts.key_match || sts.probe_last) state_nxt = S_DONE;
          else state_nxt = S_READ;
        end else begin
          if (sts.mark_empty || (sts.mark_used && sts.key_match) || sts.probe_last)
            state_nxt = S_DONE;
          else
            state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.status = ST_MISSING;
    in_ready   = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_READ: ;
      S_CHECK: begin
        if (sts.kind == KIND_INSERT) begin
          priority if (!sts.mark_used) begin
            cmd.wr_insert  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_INSERTED;
          end else if (sts.key_match) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_DUPLICATE;
          end else if (sts.probe_last) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_LIMIT;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end else begin
          // search and remove pass deleted slots
          priority if (sts.mark_empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_MISSING;
          end else if (sts.mark_used && sts.key_match) begin
            cmd.set_status = 1'b1;
            if (sts.kind == KIND_REMOVE) begin
              cmd.wr_remove = 1'b1;
              cmd.status    = ST_REMOVED;
            end else begin
              cmd.status = ST_FOUND;
            end
          end else if (sts.probe_last) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_MISSING;
          end else begin
            cmd.probe_adv = 1'b1;
          end
        end
      end
      S_DONE: cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/qpht_dp.sv =====
// Datapath: size register, radix-4 modulo unit, probe position update,
// slot memory with its clear sweep, live count and the result register.
// Depends on qpht_pkg; controlled by qpht_ctrl through qpht_cmd_t.
module qpht_dp #(
  parameter int SLOT_CAPACITY = qpht_pkg::SLOT_CAPACITY_DEF,
  parameter int KEY_BITS      = qpht_pkg::KEY_BITS_DEF,
  parameter int SLOT_W        = $clog2(SLOT_CAPACITY),
  parameter int CNT_W         = $clog2(SLOT_CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [qpht_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic [qpht_pkg::KIND_W-1:0]  in_kind,
  input  logic [KEY_BITS-1:0]          in_key,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [qpht_pkg::STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [CNT_W-1:0]             out_occupancy,
  input  qpht_pkg::qpht_cmd_t          cmd,
  output qpht_pkg::qpht_sts_t          sts
);
  import qpht_pkg::*;

  localparam int POS_W     = (SLOT_W > SIZE_W) ? SLOT_W : SIZE_W;
  localparam int KPAD      = KEY_BITS + (KEY_BITS % 2);
  localparam int STEPS     = KPAD / 2;
  localparam int DCW       = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int WORD_W    = 2 + KEY_BITS;
  localparam int SIZE_INIT = (SIZE_RESET > SLOT_CAPACITY) ? SLOT_CAPACITY : SIZE_RESET;

  // configuration
  logic [SIZE_W-1:0] size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(SIZE_INIT);
    end else if (cfg_we) begin
      priority if (int'(cfg_wdata) < SIZE_MIN) size_r <= SIZE_W'(SIZE_MIN);
      else if (int'(cfg_wdata) > SLOT_CAPACITY) size_r <= SIZE_W'(SLOT_CAPACITY);
      else size_r <= cfg_wdata;
    end
  end

  // request latch and modulo unit, two quotient bits per cycle
  logic [KEY_BITS-1:0] key_r;
  logic [KIND_W-1:0]   kind_r;
  logic [KPAD-1:0]     div_sh_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [DCW-1:0]      div_cnt_r;
  logic [SIZE_W:0]     t1, r1, t2, r2, size_x;
  logic [SIZE_W-1:0]   rem_nxt;

  always_comb begin
    size_x  = {1'b0, size_r};
    t1      = {rem_r, div_sh_r[KPAD-1]};
    r1      = (t1 >= size_x) ? t1 - size_x : t1;
    t2      = {r1[SIZE_W-1:0], div_sh_r[KPAD-2]};
    r2      = (t2 >= size_x) ? t2 - size_x : t2;
    rem_nxt = r2[SIZE_W-1:0];
  end

  // probe position (home + i*i) mod size, kept incrementally
  logic [POS_W-1:0]  pos_r, delta_r, size_p, pos_nxt, delta_nxt;
  logic [SIZE_W-1:0] probe_i_r;
  logic [POS_W:0]    pos_sum, delta_sum;

  always_comb begin
    size_p    = POS_W'(size_r);
    pos_sum   = {1'b0, pos_r} + {1'b0, delta_r};
    pos_nxt   = (pos_sum >= {1'b0, size_p}) ? POS_W'(pos_sum - {1'b0, size_p})
                                            : POS_W'(pos_sum);
    delta_sum = {1'b0, delta_r} + (POS_W+1)'(2);
    delta_nxt = (delta_sum >= {1'b0, size_p}) ? POS_W'(delta_sum - {1'b0, size_p})
                                              : POS_W'(delta_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_key;
      kind_r    <= in_kind;
      div_sh_r  <= KPAD'(in_key);
      rem_r     <= '0;
      div_cnt_r <= DCW'(STEPS - 1);
    end else if (cmd.div_step) begin
      div_sh_r  <= div_sh_r << 2;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r - DCW'(1);
    end
    if (cmd.div_step && sts.div_last) begin
      pos_r     <= POS_W'(rem_nxt);
      delta_r   <= POS_W'(1);
      probe_i_r <= '0;
    end else if (cmd.probe_adv) begin
      pos_r     <= pos_nxt;
      delta_r   <= delta_nxt;
      probe_i_r <= probe_i_r + SIZE_W'(1);
    end
  end

  // slot memory: {mark, key}
  logic [WORD_W-1:0] mem [SLOT_CAPACITY];
  logic [WORD_W-1:0] rd_r, wdata;
  logic [SLOT_W-1:0] clr_addr_r, raddr, waddr;
  logic              mem_we;
  logic [KEY_BITS-1:0] rd_key;
  logic [1:0]          rd_mark;

  assign raddr   = pos_r[SLOT_W-1:0];
  assign waddr   = cmd.clr_step ? clr_addr_r : raddr;
  assign mem_we  = cmd.clr_step | cmd.wr_insert | cmd.wr_remove;
  assign rd_key  = rd_r[KEY_BITS-1:0];
  assign rd_mark = rd_r[WORD_W-1 -: 2];

  always_comb begin
    priority if (cmd.clr_step) wdata = {MARK_EMPTY, {KEY_BITS{1'b0}}};
    else if (cmd.wr_insert)    wdata = {MARK_USED, key_r};
    else                       wdata = {MARK_GONE, rd_key};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  // live count and result
  logic [CNT_W-1:0]    count_r;
  status_t             res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [CNT_W-1:0]    out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_insert) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.wr_remove && count_r != '0) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= ST_MISSING;
      res_slot_r   <= '0;
    end else if (cmd.set_status) begin
      res_status_r <= cmd.status;
      if (cmd.status == ST_INSERTED || cmd.status == ST_FOUND || cmd.status == ST_REMOVED)
        res_slot_r <= raddr;
      else
        res_slot_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_occ_r    <= count_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_occupancy = out_occ_r;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_addr_r == SLOT_W'(SLOT_CAPACITY - 1));
    sts.div_last   = (div_cnt_r == '0);
    sts.mark_empty = (rd_mark == MARK_EMPTY);
    sts.mark_used  = (rd_mark == MARK_USED);
    sts.key_match  = (rd_key == key_r);
    sts.probe_last = (probe_i_r == (size_r >> 1));
    sts.out_free   = !out_valid_r || out_ready;
    sts.kind       = kind_r;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= SLOT_CAPACITY)
    else $error("live count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not bump live count");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.probe_adv || (cmd.div_step && sts.div_last)) |=> pos_r < size_p)
    else $error("probe position outside table");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");
`endif

endmodule

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// Top level of the quadratic-probe open-addressing hash table.
// Depends on qpht_pkg, qpht_if (channel interfaces), qpht_ctrl and qpht_dp.
//
//  channel  dir  handshake           payload
//  in_req   in   valid/ready         kind, key
//  out_rsp  out  valid/ready         status, slot, occupancy
//  cfg      in   cfg_we (no ready)   cfg_wdata = table size
//
// A request is accepted, reduced modulo the table size in the radix-4 modulo
// unit, probed with a memory read and a check per probe, and its result is
// loaded into the result register.
// After reset a clear sweep writes every slot empty, during which in_req is
// not ready; cfg writes are taken throughout.
// A new request is taken while a result waits; the next result waits in
// the sequencer until out_rsp has moved the previous transfer.
module quadratic_probe_hash_table #(
  parameter int SLOT_CAPACITY = qpht_pkg::SLOT_CAPACITY_DEF,
  parameter int KEY_BITS      = qpht_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [qpht_pkg::SIZE_W-1:0] cfg_wdata,
  qpht_req_if.sink                    in_req,
  qpht_rsp_if.source                  out_rsp
);
  import qpht_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_CAPACITY);
  localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);

  qpht_cmd_t cmd;
  qpht_sts_t sts;

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_kind  (in_req.kind),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qpht_dp #(
    .SLOT_CAPACITY (SLOT_CAPACITY),
    .KEY_BITS      (KEY_BITS),
    .SLOT_W        (SLOT_W),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_req.kind),
    .in_key        (in_req.key),
    .out_ready     (out_rsp.ready),
    .out_valid     (out_rsp.valid),
    .out_status    (out_rsp.status),
    .out_slot      (out_rsp.slot),
    .out_occupancy (out_rsp.occupancy),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
